// ===== rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Request and result payload types, opcodes, status codes and the
// default sizes used by the top level.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DepthDef     = 16;
  localparam int DataWidthDef = 32;

  localparam int ItemW   = 32;
  localparam int ResultW = 32;
  localparam int CountW  = 5;
  localparam int OpW     = 3;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [ItemW-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [ResultW-1:0] result_value;
    logic [1:0]         status;
    logic [CountW-1:0]  element_count;
  } rsp_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load_req;
    logic rd_en;
    logic commit;
  } dq_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic need_read;
  } dq_sts_t;

endpackage

// ===== rtl/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds until the
// next read enable.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dq_datapath.sv =====
// ----------------------------------------------------------------------------
// dq_datapath: ring pointers, element count, storage and result register
// Decodes the held request against the front pointer and the count, drives
// the ring RAM and loads the result register when the sequencer commits.
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int Depth     = dq_pkg::DepthDef,
  parameter int DataWidth = dq_pkg::DataWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dq_pkg::req_t    req_i,
  input  dq_pkg::dq_cmd_t cmd_i,
  output dq_pkg::dq_sts_t sts_o,
  output dq_pkg::rsp_t    rsp_o
);

  import dq_pkg::*;

  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int SumW  = CntW + 1;

  req_t                 req_q;
  rsp_t                 rsp_q;
  logic [AddrW-1:0]     front_q, front_d;
  logic [CntW-1:0]      count_q, count_d;

  logic                 full, empty;
  logic [AddrW-1:0]     front_dec, front_inc, back_push, back_last;
  logic [SumW-1:0]      sum_push, sum_last;
  logic [AddrW-1:0]     raddr, waddr;
  logic                 push_ok, rd_op;
  status_e              status;
  logic [DataWidth-1:0] word, rdata;

  assign full  = (count_q == CntW'(Depth));
  assign empty = (count_q == '0);
  assign word  = DataWidth'(req_q.item_value);

  assign front_dec = (front_q == '0) ? AddrW'(Depth - 1) : front_q - 1'b1;
  assign front_inc = (front_q == AddrW'(Depth - 1)) ? '0 : front_q + 1'b1;

  // Front plus count stays below twice the depth, so one subtract wraps it.
  assign sum_push  = SumW'(front_q) + SumW'(count_q);
  assign sum_last  = sum_push - 1'b1;
  assign back_push = (sum_push >= SumW'(Depth)) ? AddrW'(sum_push - SumW'(Depth))
                                                : AddrW'(sum_push);
  assign back_last = (sum_last >= SumW'(Depth)) ? AddrW'(sum_last - SumW'(Depth))
                                                : AddrW'(sum_last);

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    status  = ST_OK;
    push_ok = 1'b0;
    rd_op   = 1'b0;
    waddr   = front_dec;
    raddr   = front_q;
    case (req_q.opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          push_ok = 1'b1;
          front_d = front_dec;
          count_d = count_q + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        waddr = back_push;
        if (full) begin
          status = ST_FULL;
        end else begin
          push_ok = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_op = 1'b1;
          if (req_q.opcode == OP_POP_FRONT) begin
            front_d = front_inc;
            count_d = count_q - 1'b1;
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        raddr = back_last;
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_op = 1'b1;
          if (req_q.opcode == OP_POP_BACK) begin
            count_d = count_q - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign sts_o.need_read = rd_op;

  dq_ram #(
    .Width(DataWidth),
    .Depth(Depth)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit & push_ok),
    .waddr_i(waddr),
    .wdata_i(word),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.commit) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.commit) begin
      rsp_q.result_value  <= rd_op ? ResultW'(rdata) : '0;
      rsp_q.status        <= status;
      rsp_q.element_count <= CountW'(count_d);
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== rtl/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl: request sequencer of the double-ended queue
// Takes a request, issues the ring read when one is needed and commits the
// result once the output register is free.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  dq_pkg::dq_sts_t sts_i,
  output dq_pkg::dq_cmd_t cmd_o
);

  import dq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_req = in_valid_i;
      end
      S_EXEC: begin
        if (sts_i.need_read) begin
          cmd_o.rd_en = 1'b1;
        end else begin
          cmd_o.commit = out_free;
        end
      end
      S_READ: begin
        cmd_o.commit = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (sts_i.need_read) begin
            state_q <= S_READ;
          end else if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_READ: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      // A commit refills the output register in the cycle it is emptied.
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue held as a ring
// Push and pop at either end, or peek, with one result per request.
// ----------------------------------------------------------------------------
// Usage: a request (opcode and item_value) enters on the in channel and its
// single result (result_value, status, element_count) leaves on the out
// channel, both with valid/ready handshakes. Requests are handled one at a
// time. A request accepted at one edge is evaluated in the next cycle; a
// push, an error or an unused opcode loads its result into the output
// register from the evaluate state (S_EXEC), and a pop or peek from the read
// state (S_READ) after it, because the ring RAM has a registered read. The
// input is ready again as soon as the result is loaded, so a new request is
// taken only once the previous one's result is in the output register. If
// the receiver stalls, the waiting result stays in the output register; the
// next request is still accepted and worked on, and it completes once that
// register is emptied.
// Reset empties the queue (front pointer and count to zero) and drops any
// pending result; the ring contents are not cleared, since only written
// entries are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int Depth     = dq_pkg::DepthDef,
  parameter int DataWidth = dq_pkg::DataWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  dq_pkg::req_t req_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output dq_pkg::rsp_t rsp_o
);

  import dq_pkg::*;

  dq_cmd_t cmd;
  dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dq_datapath #(
    .Depth    (Depth),
    .DataWidth(DataWidth)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (rsp_o)
  );

endmodule

// ===== tb/dq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dq_checker: result checker for the double-ended queue
// Watches both channels. Each accepted request is run through a local model
// of the ring, and the expected result is queued. Each result that leaves
// the block is compared, field by field, with the oldest expected result.
// ----------------------------------------------------------------------------
module dq_checker
  import dq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  req_t req_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  rsp_t rsp_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   full_seen_o,
  output int   empty_seen_o
);

  localparam int Depth      = DepthDef;
  localparam int IdxW       = $clog2(Depth);
  localparam int MaxReports = 10;

  logic [ResultW-1:0] ring_q [Depth];
  logic [IdxW-1:0]    front_q;
  logic [CountW-1:0]  fill_q;
  rsp_t               expected_rsp_q [$];
  rsp_t               exp_rsp;

  // Applies one request to the local ring and returns the result it earns.
  function automatic rsp_t deque_apply(req_t r);
    rsp_t            res;
    logic [IdxW-1:0] pos;
    res        = '0;
    res.status = ST_OK;
    case (r.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill_q == CountW'(Depth)) begin
          res.status = ST_FULL;
        end else begin
          if (r.opcode == OP_PUSH_FRONT) begin
            front_q = front_q - 1'b1;
            pos     = front_q;
          end else begin
            pos = front_q + IdxW'(fill_q);
          end
          ring_q[pos] = r.item_value;
          fill_q      = fill_q + 1'b1;
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT, OP_POP_BACK, OP_PEEK_BACK: begin
        if (fill_q == '0) begin
          res.status = ST_EMPTY;
        end else begin
          // The back element sits count-1 places after the front, modulo the depth.
          if (r.opcode == OP_POP_FRONT || r.opcode == OP_PEEK_FRONT) begin
            pos = front_q;
          end else begin
            pos = front_q + IdxW'(fill_q - 1'b1);
          end
          res.result_value = ring_q[pos];
          if (r.opcode == OP_POP_FRONT) begin
            front_q = front_q + 1'b1;
            fill_q  = fill_q - 1'b1;
          end else if (r.opcode == OP_POP_BACK) begin
            fill_q = fill_q - 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.element_count = fill_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q      = '0;
      fill_q       = '0;
      expected_rsp_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      full_seen_o  = 0;
      empty_seen_o = 0;
    end else begin
      // Results leave only after their request has been accepted and evaluated, so the
      // output side is handled before this edge's request is queued.
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          if (fail_count_o < MaxReports) begin
            $display("%0t: result with no request outstanding: value %h status %0d count %0d",
                     $realtime, rsp_i.result_value, rsp_i.status, rsp_i.element_count);
          end
          fail_count_o++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          checked_o++;
          if (rsp_i.result_value !== exp_rsp.result_value ||
              rsp_i.status !== exp_rsp.status ||
              rsp_i.element_count !== exp_rsp.element_count) begin
            if (fail_count_o < MaxReports) begin
              $display("%0t: result %0d wrong: expected value %h status %0d count %0d",
                       $realtime, checked_o, exp_rsp.result_value, exp_rsp.status,
                       exp_rsp.element_count);
              $display("%0t:   got value %h status %0d count %0d", $realtime,
                       rsp_i.result_value, rsp_i.status, rsp_i.element_count);
            end
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        exp_rsp = deque_apply(req_i);
        if (exp_rsp.status == ST_FULL) full_seen_o++;
        if (exp_rsp.status == ST_EMPTY) empty_seen_o++;
        expected_rsp_q.push_back(exp_rsp);
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for the double-ended queue
// Drives directed requests at the empty and full boundaries, then biased
// random requests that swing the queue between empty and full under four
// pacing modes and a long output stall. The checker judges every result.
// ----------------------------------------------------------------------------
module tb;
  import dq_pkg::*;

  localparam int ResetCycles   = 11;
  localparam int IdleLimit     = 4000;
  localparam int SettleCycles  = 8;
  localparam int ItemsPerPhase = 300;
  localparam int BiasRun       = 40;
  localparam int HoldCycles    = 150;
  localparam int HoldItems     = 24;

  // Opcodes outside the defined set; the block must answer them harmlessly.
  localparam logic [OpW-1:0] OpSpareLo = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t rsp_o;

  int tx_idle_pct;
  int rx_stall_pct;
  int rx_hold_cycles;
  int sent_count;
  int idle_cycles;
  int fail_count;
  int pending;
  int checked;
  int full_seen;
  int empty_seen;

  double_ended_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_i      (req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .rsp_o      (rsp_o)
  );

  dq_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .req_i       (req_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .rsp_i       (rsp_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .full_seen_o (full_seen),
    .empty_seen_o(empty_seen)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Receiver: random stalls, or one long hold when the stimulus asks for it.
  always begin
    @(posedge clk_i);
    if (rx_hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      repeat (rx_hold_cycles) @(posedge clk_i);
      rx_hold_cycles = 0;
    end
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: nothing moved on either channel for %0d cycles", IdleLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic req_t make_req(logic [OpW-1:0] op, logic [ItemW-1:0] value);
    req_t r;
    r.opcode     = op;
    r.item_value = value;
    return r;
  endfunction

  function automatic req_t rand_request(int push_pct);
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0:       r.item_value = '0;
      1:       r.item_value = '1;
      default: r.item_value = $urandom;
    endcase
    if (pick < 2) begin
      r.opcode = $urandom_range(1) ? OpSpareHi : OpSpareLo;
    end else if (pick < push_pct) begin
      r.opcode = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    end else begin
      case ($urandom_range(3))
        0:       r.opcode = OP_POP_FRONT;
        1:       r.opcode = OP_POP_BACK;
        2:       r.opcode = OP_PEEK_FRONT;
        default: r.opcode = OP_PEEK_BACK;
      endcase
    end
    return r;
  endfunction

  // Offers one request, holds it until taken, then maybe leaves a gap.
  task automatic send_request(req_t r);
    in_valid_i <= 1'b1;
    req_i      <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // Stops offering and waits until every outstanding request has its result.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Alternates between filling and draining runs so both ends of the range are hit.
  task automatic run_phase(int tx_pct, int rx_pct, int n_items);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < n_items; i++) begin
      send_request(rand_request(((i / BiasRun) % 2 == 0) ? 72 : 25));
    end
    drain();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_i          = '0;
    out_ready_i    = 1'b0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    rx_hold_cycles = 0;
    sent_count     = 0;
    idle_cycles    = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Underflow at both ends, and a spare opcode on an empty queue.
    send_request(make_req(OP_POP_FRONT, '1));
    send_request(make_req(OP_POP_BACK, '1));
    send_request(make_req(OP_PEEK_FRONT, '0));
    send_request(make_req(OP_PEEK_BACK, '1));
    send_request(make_req(OpSpareLo, '1));
    // Fill from both ends so the front pointer wraps below zero.
    for (int k = 0; k < DepthDef; k++) begin
      send_request(make_req((k % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                            (k == 0) ? '0 : (k == 1) ? '1 : 32'h5A00_0000 + k));
    end
    // Overflow at both ends, then read and remove at both ends.
    send_request(make_req(OP_PUSH_FRONT, '1));
    send_request(make_req(OP_PUSH_BACK, '1));
    send_request(make_req(OpSpareHi, '0));
    send_request(make_req(OP_PEEK_FRONT, '0));
    send_request(make_req(OP_PEEK_BACK, '0));
    send_request(make_req(OP_POP_FRONT, '0));
    send_request(make_req(OP_POP_BACK, '0));
    drain();

    run_phase(0, 0, ItemsPerPhase);
    run_phase(73, 0, ItemsPerPhase);
    run_phase(0, 73, ItemsPerPhase);
    run_phase(29, 29, ItemsPerPhase);

    // Long output stall while requests keep coming, so the input backs up.
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    rx_hold_cycles = HoldCycles;
    for (int i = 0; i < HoldItems; i++) begin
      send_request(rand_request(50));
    end
    drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results under four pacing modes and a long stall.",
             sent_count, checked);
    $display("Requests refused on a full queue: %0d; on an empty queue: %0d; failures: %0d.",
             full_seen, empty_seen, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
